>>> src/alarm_pulse_and_clip_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alarm pulse and clip sequencer
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ALARM_PULSE_AND_CLIP_SEQUENCER_ASSERT_SVH
`define ALARM_PULSE_AND_CLIP_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside reset.
`define APCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define APCS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define APCS_ASSERT(label, clk, rst_n, prop, msg)

`define APCS_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> src/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg
// Shared types and constants of the alarm pulse and clip sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package apcs_pkg;

    localparam int MS_WIDTH      = 16;
    localparam int ERR_WIDTH     = 32;
    localparam int CFG_IDX_WIDTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_ON     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PULSE_OFF    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLIP_TIMEOUT = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLIP_GAP     = 2'd3;

    // configuration reset values
    localparam logic [MS_WIDTH-1:0] PULSE_ON_RST     = 16'd150;
    localparam logic [MS_WIDTH-1:0] PULSE_OFF_RST    = 16'd850;
    localparam logic [MS_WIDTH-1:0] CLIP_TIMEOUT_RST = 16'd5000;
    localparam logic [MS_WIDTH-1:0] CLIP_GAP_RST     = 16'd1000;

    typedef enum logic [1:0] {
        KIND_POLL       = 2'd0,
        KIND_SET_WANTED = 2'd1,
        KIND_RETRY      = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PLAY  = 2'd1,
        PH_DRAIN = 2'd2,
        PH_GAP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [MS_WIDTH-1:0] pulse_on_ms;
        logic [MS_WIDTH-1:0] pulse_off_ms;
        logic [MS_WIDTH-1:0] clip_timeout_ms;
        logic [MS_WIDTH-1:0] clip_gap_ms;
    } t_cfg;

    // event fields other than the time stamp
    typedef struct packed {
        logic [1:0]           kind;
        logic                 wanted;
        logic                 hooks_ready;
        logic                 audio_drained;
        logic [ERR_WIDTH-1:0] audio_error_count;
        logic                 start_accepted;
    } t_event;

    typedef struct packed {
        logic   motor_on;
        logic   motor_edge;
        logic   start_request;
        logic   cancel_request;
        logic   fault_flag;
        logic   retry_accepted;
        t_phase clip_phase;
    } t_result;

endpackage

`default_nettype wire

>>> src/apcs_in_reg.sv
// ----------------------------------------------------------------------------
// apcs_in_reg
// Input register: holds one event until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_in_reg #(
    parameter int TW = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire apcs_pkg::t_event       i_event,
    input  wire logic signed [TW-1:0]   i_now,
    output logic                        o_valid,
    input  wire logic                   i_take,
    output apcs_pkg::t_event            o_event,
    output logic signed [TW-1:0]        o_now
);
    import apcs_pkg::*;

    logic             r_valid;
    t_event           r_event;
    logic signed [TW-1:0] r_now;

    // refill in the same cycle the held event moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_event = r_event;
    assign o_now   = r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_event <= i_event;
            r_now   <= i_now;
        end
    end

endmodule

`default_nettype wire

>>> src/apcs_core.sv
// ----------------------------------------------------------------------------
// apcs_core
// Sequencer state and the single-pass update for one event.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alarm_pulse_and_clip_sequencer_assert.svh"

module apcs_core #(
    parameter int TW = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire apcs_pkg::t_cfg         i_cfg,
    input  wire apcs_pkg::t_event       i_event,
    input  wire logic signed [TW-1:0]   i_now,
    output apcs_pkg::t_result           o_result
);
    import apcs_pkg::*;

    localparam logic signed [TW:0] TIME_MAX = {2'b00, {(TW-1){1'b1}}};

    logic                  r_want, n_want;
    logic                  r_motor, n_motor;
    logic signed [TW-1:0]  r_motor_since, n_motor_since;
    logic signed [TW-1:0]  r_next_pulse, n_next_pulse;
    t_phase                r_phase, n_phase;
    logic signed [TW-1:0]  r_phase_since, n_phase_since;
    logic                  r_owned, n_owned;
    logic                  r_fault, n_fault;
    logic signed [TW-1:0]  r_last_time, n_last_time;
    logic [ERR_WIDTH-1:0]  r_err_snap, n_err_snap;

    logic ev_edge, ev_start, ev_cancel, retry_ok;

    // exact difference, one bit wider than a time stamp
    function automatic logic signed [TW:0] tdiff(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
        return {a[TW-1], a} - {b[TW-1], b};
    endfunction

    function automatic logic signed [TW:0] ms_ext(input logic [MS_WIDTH-1:0] ms);
        return $signed({{(TW+1-MS_WIDTH){1'b0}}, ms});
    endfunction

    always_comb begin
        logic run_poll;
        logic retry_try;
        logic done;
        logic do_fail;
        logic signed [TW:0] sum;

        n_want        = r_want;
        n_motor       = r_motor;
        n_motor_since = r_motor_since;
        n_next_pulse  = r_next_pulse;
        n_phase       = r_phase;
        n_phase_since = r_phase_since;
        n_owned       = r_owned;
        n_fault       = r_fault;
        n_last_time   = r_last_time;
        n_err_snap    = r_err_snap;
        ev_edge       = 1'b0;
        ev_start      = 1'b0;
        ev_cancel     = 1'b0;
        run_poll      = 1'b0;
        retry_try     = 1'b0;
        done          = 1'b0;
        do_fail       = 1'b0;
        sum           = {{TW{1'b0}}, 1'b0};

        unique case (i_event.kind)
            KIND_POLL: begin
                run_poll = 1'b1;
            end
            KIND_SET_WANTED: begin
                if (i_event.wanted != r_want) begin
                    n_want = i_event.wanted;
                    if (i_event.wanted) begin
                        n_next_pulse = i_now;
                    end else begin
                        if (n_motor) ev_edge = 1'b1;
                        n_motor = 1'b0;
                        if (n_owned && i_event.hooks_ready) ev_cancel = 1'b1;
                        n_phase       = PH_DRAIN;
                        n_phase_since = i_now;
                    end
                    run_poll = 1'b1;
                end
            end
            KIND_RETRY: begin
                if (r_fault && i_event.hooks_ready && i_event.audio_drained &&
                    i_now >= r_last_time) begin
                    n_fault      = 1'b0;
                    n_owned      = 1'b0;
                    n_phase      = PH_IDLE;
                    n_next_pulse = i_now;
                    run_poll     = 1'b1;
                    retry_try    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (!run_poll) begin
            done = 1'b1;
        end else if (!i_event.hooks_ready || i_now[TW-1] ||
                     (!n_last_time[TW-1] && i_now < n_last_time)) begin
            do_fail = 1'b1;
            done    = 1'b1;
        end else begin
            n_last_time = i_now;
            if (n_fault) begin
                if (n_motor) ev_edge = 1'b1;
                n_motor = 1'b0;
                done    = 1'b1;
            end else if (n_owned && i_event.audio_error_count != n_err_snap) begin
                do_fail = 1'b1;
                done    = 1'b1;
            end
        end

        // motor pulse train and clip phase progress
        if (!done) begin
            if (!n_want) begin
                if (n_motor) ev_edge = 1'b1;
                n_motor = 1'b0;
            end else if (n_motor &&
                         tdiff(i_now, n_motor_since) >= ms_ext(i_cfg.pulse_on_ms)) begin
                ev_edge = 1'b1;
                n_motor = 1'b0;
                // time is non-negative here, so overflow shows in the top bit
                sum = {i_now[TW-1], i_now} + ms_ext(i_cfg.pulse_off_ms);
                n_next_pulse = sum[TW-1] ? TIME_MAX[TW-1:0] : sum[TW-1:0];
            end else if (!n_motor && i_now >= n_next_pulse) begin
                ev_edge       = 1'b1;
                n_motor       = 1'b1;
                n_motor_since = i_now;
            end

            if (n_phase == PH_PLAY) begin
                if (i_event.audio_error_count != n_err_snap ||
                    tdiff(i_now, n_phase_since) > ms_ext(i_cfg.clip_timeout_ms)) begin
                    do_fail = 1'b1;
                    done    = 1'b1;
                end else if (!i_event.audio_drained) begin
                    done = 1'b1;
                end else begin
                    n_owned       = 1'b0;
                    n_phase       = PH_GAP;
                    n_phase_since = i_now;
                end
            end else if (n_phase == PH_DRAIN) begin
                if (!i_event.audio_drained) begin
                    if (tdiff(i_now, n_phase_since) > ms_ext(i_cfg.clip_timeout_ms)) begin
                        do_fail = 1'b1;
                    end
                    done = 1'b1;
                end else begin
                    n_owned = 1'b0;
                    n_phase = PH_IDLE;
                end
            end
        end

        // next clip start
        if (!done) begin
            if (!n_want || (n_phase == PH_GAP &&
                            tdiff(i_now, n_phase_since) < ms_ext(i_cfg.clip_gap_ms))) begin
                done = 1'b1;
            end else if (!i_event.audio_drained) begin
                do_fail = 1'b1;
            end else begin
                n_err_snap = i_event.audio_error_count;
                ev_start   = 1'b1;
                if (!i_event.start_accepted) begin
                    do_fail = 1'b1;
                end else begin
                    n_owned       = 1'b1;
                    n_phase       = PH_PLAY;
                    n_phase_since = i_now;
                end
            end
        end

        // a fault ends the event, so it applies last
        if (do_fail) begin
            n_fault = 1'b1;
            if (n_motor) ev_edge = 1'b1;
            n_motor = 1'b0;
            if (n_owned && i_event.hooks_ready) ev_cancel = 1'b1;
            n_phase       = PH_DRAIN;
            n_phase_since = i_now;
        end

        retry_ok = retry_try && !n_fault;
    end

    always_comb begin
        o_result.motor_on       = n_motor;
        o_result.motor_edge     = ev_edge;
        o_result.start_request  = ev_start;
        o_result.cancel_request = ev_cancel;
        o_result.fault_flag     = n_fault;
        o_result.retry_accepted = retry_ok;
        o_result.clip_phase     = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want        <= 1'b0;
            r_motor       <= 1'b0;
            r_motor_since <= '0;
            r_next_pulse  <= '0;
            r_phase       <= PH_IDLE;
            r_phase_since <= '0;
            r_owned       <= 1'b0;
            r_fault       <= 1'b0;
            r_last_time   <= '1;
            r_err_snap    <= '0;
        end else if (i_step) begin
            r_want        <= n_want;
            r_motor       <= n_motor;
            r_motor_since <= n_motor_since;
            r_next_pulse  <= n_next_pulse;
            r_phase       <= n_phase;
            r_phase_since <= n_phase_since;
            r_owned       <= n_owned;
            r_fault       <= n_fault;
            r_last_time   <= n_last_time;
            r_err_snap    <= n_err_snap;
        end
    end

    // a latched fault always parks the motor and sits in draining
    `APCS_ASSERT(a_fault_parks, i_clk, i_rst_n, r_fault |-> (!r_motor && r_phase == PH_DRAIN), "fault without drain or with motor on")
    // an owned clip is either playing or draining
    `APCS_ASSERT(a_owned_phase, i_clk, i_rst_n, r_owned |-> (r_phase == PH_PLAY || r_phase == PH_DRAIN), "owned clip outside play or drain")
    `APCS_ASSERT(a_start_plays, i_clk, i_rst_n, (i_step && ev_start && !n_fault) |=> (r_owned && r_phase == PH_PLAY), "accepted start did not enter play")
    `APCS_ASSERT_NEVER(a_retry_fault, i_clk, i_rst_n, retry_ok && n_fault, "retry reported with fault latched")

endmodule

`default_nettype wire

>>> src/apcs_out_reg.sv
// ----------------------------------------------------------------------------
// apcs_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire apcs_pkg::t_result   i_result,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output apcs_pkg::t_result        o_result
);
    import apcs_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> src/alarm_pulse_and_clip_sequencer.sv
// ----------------------------------------------------------------------------
// alarm_pulse_and_clip_sequencer
// Event-driven alarm sequencer: motor pulse train plus repeating audio clip
// with fault latching and retry.
// ----------------------------------------------------------------------------
// Usage:
//   Events (poll, set wanted, retry) with a signed time stamp enter on the
//   i_in_* channel (valid/ready); each event gives exactly one result on the
//   o_out_* channel (valid/ready). A transfer happens when valid and ready are
//   both high at a rising edge.
//   A transferred event is held in the input register; its result is loaded
//   into the result register once that register is free, and is sent from it.
//   Throughput: one event per cycle while the receiver takes results; the
//   update of the sequencer state is one pass of compare-and-select logic
//   between the two registers. When the receiver stalls, the result register
//   holds, the input register still takes one more event, and o_in_ready then
//   drops until the result is taken.
//   Reset (i_rst_n low, synchronous) empties both registers, loads the default
//   timing registers and returns the sequencer to idle with no time seen.
//   The user must write the timing registers through i_cfg_we / i_cfg_index /
//   i_cfg_wdata only while no event is in flight; the block itself has no check.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_pulse_and_clip_sequencer #(
    parameter int TIME_WIDTH = 48
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [15:0]                   i_cfg_wdata,
    // events
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_kind,
    input  wire logic signed [TIME_WIDTH-1:0]  i_now_ms,
    input  wire logic                          i_wanted,
    input  wire logic                          i_hooks_ready,
    input  wire logic                          i_audio_drained,
    input  wire logic [31:0]                   i_audio_error_count,
    input  wire logic                          i_start_accepted,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_motor_on,
    output logic                               o_motor_edge,
    output logic                               o_start_request,
    output logic                               o_cancel_request,
    output logic                               o_fault_flag,
    output logic                               o_retry_accepted,
    output logic [1:0]                         o_clip_phase
);
    import apcs_pkg::*;

    t_cfg    r_cfg;
    t_event  in_event, ev_held;
    logic signed [TIME_WIDTH-1:0] now_held;
    logic    held_valid;
    logic    res_ready;
    logic    step;
    t_result core_result, out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_on_ms     <= PULSE_ON_RST;
            r_cfg.pulse_off_ms    <= PULSE_OFF_RST;
            r_cfg.clip_timeout_ms <= CLIP_TIMEOUT_RST;
            r_cfg.clip_gap_ms     <= CLIP_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULSE_ON:     r_cfg.pulse_on_ms     <= i_cfg_wdata;
                CFG_PULSE_OFF:    r_cfg.pulse_off_ms    <= i_cfg_wdata;
                CFG_CLIP_TIMEOUT: r_cfg.clip_timeout_ms <= i_cfg_wdata;
                CFG_CLIP_GAP:     r_cfg.clip_gap_ms     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_event.kind              = i_kind;
        in_event.wanted            = i_wanted;
        in_event.hooks_ready       = i_hooks_ready;
        in_event.audio_drained     = i_audio_drained;
        in_event.audio_error_count = i_audio_error_count;
        in_event.start_accepted    = i_start_accepted;
    end

    // state advances only when the held event lands in the result register
    assign step = held_valid && res_ready;

    apcs_in_reg #(
        .TW (TIME_WIDTH)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_event (in_event),
        .i_now   (i_now_ms),
        .o_valid (held_valid),
        .i_take  (res_ready),
        .o_event (ev_held),
        .o_now   (now_held)
    );

    apcs_core #(
        .TW (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (r_cfg),
        .i_event  (ev_held),
        .i_now    (now_held),
        .o_result (core_result)
    );

    apcs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (res_ready),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_motor_on       = out_result.motor_on;
    assign o_motor_edge     = out_result.motor_edge;
    assign o_start_request  = out_result.start_request;
    assign o_cancel_request = out_result.cancel_request;
    assign o_fault_flag     = out_result.fault_flag;
    assign o_retry_accepted = out_result.retry_accepted;
    assign o_clip_phase     = out_result.clip_phase;

endmodule

`default_nettype wire

>>> tb/alarm_pulse_and_clip_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_pulse_and_clip_sequencer_test
// Self-checking bench: a directed table, then random event streams over
// several timing settings, checked against an in-bench model of the
// sequencer, with random idle cycles and stalls on both channels.
// ----------------------------------------------------------------------------
module alarm_pulse_and_clip_sequencer_test;
    import apcs_pkg::*;

    localparam int     TW   = 48;
    localparam longint TMAX = (64'sd1 <<< (TW - 1)) - 1;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam t_result RES_QUIET = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE};
    localparam t_result RES_FAULT = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PH_DRAIN};
    localparam t_result RES_RETRY = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PH_IDLE};

    typedef struct {
        t_event                ev;
        logic signed [TW-1:0]  now;
        bit                    chk;
        t_result               typed_res;
    } t_stim_row;

    logic                 i_clk               = 1'b0;
    logic                 i_rst_n             = 1'b0;
    logic                 i_cfg_we            = 1'b0;
    logic [1:0]           i_cfg_index         = CFG_PULSE_ON;
    logic [15:0]          i_cfg_wdata         = '0;
    logic                 i_in_valid          = 1'b0;
    logic [1:0]           i_kind              = KIND_POLL;
    logic signed [TW-1:0] i_now_ms            = '0;
    logic                 i_wanted            = 1'b0;
    logic                 i_hooks_ready       = 1'b0;
    logic                 i_audio_drained     = 1'b0;
    logic [31:0]          i_audio_error_count = '0;
    logic                 i_start_accepted    = 1'b0;
    logic                 i_out_ready         = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_motor_on;
    logic                 o_motor_edge;
    logic                 o_start_request;
    logic                 o_cancel_request;
    logic                 o_fault_flag;
    logic                 o_retry_accepted;
    logic [1:0]           o_clip_phase;

    alarm_pulse_and_clip_sequencer #(.TIME_WIDTH(TW)) dut (.*);

    always #4 i_clk = ~i_clk;

    // idle profile, switched every 40 events
    int send_idle_pct[4] = '{0, 69, 0, 28};
    int recv_stall_pct[4] = '{0, 0, 69, 28};
    int n_sent = 0;
    int mode;
    assign mode = (n_sent / 40) % 4;

    always @(negedge i_clk) i_out_ready = ($urandom_range(99) >= recv_stall_pct[mode]);

    // ---------------- sequencer model ----------------
    longint  tm_on, tm_off, tm_timeout, tm_gap;
    bit      want_on, mot_lvl, owned, faulted;
    longint  mot_since, next_pulse, ph_since, last_seen;
    t_phase  ph;
    logic [31:0] err_snap;
    bit      hk_in, drained_in, accept_in;
    logic [31:0] err_in;
    bit      edge_f, start_f, cancel_f;

    t_result pending_results[$];
    int      mismatch_cnt = 0;
    longint  clock_ms = 0;
    logic [31:0] err_now = '0;
    int      step_max = 10;

    function automatic void motor_drive(bit lv);
        if (lv != mot_lvl) begin
            mot_lvl = lv;
            edge_f  = 1'b1;
        end
    endfunction

    function automatic void cancel_clip();
        if (owned && hk_in) cancel_f = 1'b1;
    endfunction

    function automatic void latch_fault(longint t);
        faulted = 1'b1;
        motor_drive(1'b0);
        cancel_clip();
        ph       = PH_DRAIN;
        ph_since = t;
    endfunction

    function automatic longint pulse_time(longint a, longint b);
        return (a > TMAX - b) ? TMAX : a + b;
    endfunction

    // times are 48-bit, so the 64-bit differences below cannot saturate
    function automatic void poll_step(longint t);
        if (!hk_in || t < 0 || (last_seen >= 0 && t < last_seen)) begin
            latch_fault(t);
            return;
        end
        last_seen = t;
        if (faulted) begin
            motor_drive(1'b0);
            return;
        end
        if (owned && err_in != err_snap) begin
            latch_fault(t);
            return;
        end
        if (!want_on) begin
            motor_drive(1'b0);
        end else if (mot_lvl && t - mot_since >= tm_on) begin
            motor_drive(1'b0);
            next_pulse = pulse_time(t, tm_off);
        end else if (!mot_lvl && t >= next_pulse) begin
            motor_drive(1'b1);
            mot_since = t;
        end
        if (ph == PH_PLAY) begin
            if (err_in != err_snap || t - ph_since > tm_timeout) begin
                latch_fault(t);
                return;
            end
            if (!drained_in) return;
            owned    = 1'b0;
            ph       = PH_GAP;
            ph_since = t;
        end else if (ph == PH_DRAIN) begin
            if (!drained_in) begin
                if (t - ph_since > tm_timeout) latch_fault(t);
                return;
            end
            owned = 1'b0;
            ph    = PH_IDLE;
        end
        if (!want_on || (ph == PH_GAP && t - ph_since < tm_gap)) return;
        // a clip not ours still in the queue
        if (!drained_in) begin
            latch_fault(t);
            return;
        end
        err_snap = err_in;
        start_f  = 1'b1;
        if (!accept_in) begin
            latch_fault(t);
            return;
        end
        owned    = 1'b1;
        ph       = PH_PLAY;
        ph_since = t;
    endfunction

    function automatic t_result predict_event(t_stim_row s);
        t_result r;
        longint  t;
        bit      retry_ok;
        t          = longint'(s.now);
        hk_in      = s.ev.hooks_ready;
        drained_in = s.ev.audio_drained;
        err_in     = s.ev.audio_error_count;
        accept_in  = s.ev.start_accepted;
        edge_f     = 1'b0;
        start_f    = 1'b0;
        cancel_f   = 1'b0;
        retry_ok   = 1'b0;
        case (s.ev.kind)
            KIND_POLL: poll_step(t);
            KIND_SET_WANTED: begin
                if (s.ev.wanted != want_on) begin
                    want_on = s.ev.wanted;
                    if (want_on) begin
                        next_pulse = t;
                    end else begin
                        motor_drive(1'b0);
                        cancel_clip();
                        ph       = PH_DRAIN;
                        ph_since = t;
                    end
                    poll_step(t);
                end
            end
            KIND_RETRY: begin
                if (faulted && hk_in && drained_in && t >= last_seen) begin
                    faulted    = 1'b0;
                    owned      = 1'b0;
                    ph         = PH_IDLE;
                    next_pulse = t;
                    poll_step(t);
                    retry_ok = !faulted;
                end
            end
            default: ;
        endcase
        r.motor_on       = mot_lvl;
        r.motor_edge     = edge_f;
        r.start_request  = start_f;
        r.cancel_request = cancel_f;
        r.fault_flag     = faulted;
        r.retry_accepted = retry_ok;
        r.clip_phase     = ph;
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic t_stim_row dir_row(logic [1:0] k, longint t, bit w, bit h, bit d,
                                          logic [31:0] e, bit a);
        t_stim_row s;
        s.ev.kind              = k;
        s.ev.wanted            = w;
        s.ev.hooks_ready       = h;
        s.ev.audio_drained     = d;
        s.ev.audio_error_count = e;
        s.ev.start_accepted    = a;
        s.now                  = t[TW-1:0];
        s.chk                  = 1'b0;
        s.typed_res            = RES_QUIET;
        return s;
    endfunction

    function automatic t_stim_row typed(t_stim_row s, t_result r);
        s.chk       = 1'b1;
        s.typed_res = r;
        return s;
    endfunction

    function automatic t_stim_row rand_row();
        t_stim_row   s;
        int          r;
        logic [63:0] rnd;
        r        = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(step_max);
        if (clock_ms > TMAX) clock_ms = TMAX;
        if (faulted && r < 40) s.ev.kind = KIND_RETRY;
        else if (r < 12)       s.ev.kind = KIND_SET_WANTED;
        else if (r < 16)       s.ev.kind = KIND_RETRY;
        else                   s.ev.kind = KIND_POLL;
        s.ev.wanted            = ($urandom_range(99) < 70);
        s.ev.hooks_ready       = 1'b1;
        s.ev.audio_drained     = ($urandom_range(99) < 65);
        s.ev.audio_error_count = err_now;
        s.ev.start_accepted    = ($urandom_range(99) < 94);
        s.now                  = clock_ms[TW-1:0];
        s.chk                  = 1'b0;
        s.typed_res            = RES_QUIET;
        rnd = {$urandom, $urandom};
        // occasional broken event
        case ($urandom_range(59))
            0: s.ev.hooks_ready = 1'b0;
            1: begin
                err_now                = $urandom;
                s.ev.audio_error_count = err_now;
            end
            2: s.now = {1'b1, rnd[TW-2:0]};
            3: s.now = TW'(clock_ms - $urandom_range(1, 40));
            4: s.ev.kind = KIND_UNUSED;
            5: s.ev.audio_error_count = rnd[31:0];
            default: ;
        endcase
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_row(t_stim_row s);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct[mode]) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind              = s.ev.kind;
        i_now_ms            = s.now;
        i_wanted            = s.ev.wanted;
        i_hooks_ready       = s.ev.hooks_ready;
        i_audio_drained     = s.ev.audio_drained;
        i_audio_error_count = s.ev.audio_error_count;
        i_start_accepted    = s.ev.start_accepted;
        i_in_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_event(s);
        pending_results.push_back(s.chk ? s.typed_res : pred);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_timing(longint on_ms, longint off_ms, longint tmo_ms, longint gap_ms);
        logic [1:0]  idx[4];
        logic [15:0] val[4];
        idx = '{CFG_PULSE_ON, CFG_PULSE_OFF, CFG_CLIP_TIMEOUT, CFG_CLIP_GAP};
        val = '{on_ms[15:0], off_ms[15:0], tmo_ms[15:0], gap_ms[15:0]};
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    = 1'b1;
            i_cfg_index = idx[i];
            i_cfg_wdata = val[i];
            @(negedge i_clk);
        end
        i_cfg_we   = 1'b0;
        tm_on      = on_ms;
        tm_off     = off_ms;
        tm_timeout = tmo_ms;
        tm_gap     = gap_ms;
        step_max   = int'((on_ms + off_ms + tmo_ms + gap_ms) / 4) + 2;
    endtask

    task automatic run_random(int n_items);
        for (int i = 0; i < n_items; i++) send_row(rand_row());
    endtask

    t_stim_row dir_tab[$];

    initial begin
        tm_on      = PULSE_ON_RST;
        tm_off     = PULSE_OFF_RST;
        tm_timeout = CLIP_TIMEOUT_RST;
        tm_gap     = CLIP_GAP_RST;
        want_on    = 1'b0;
        mot_lvl    = 1'b0;
        owned      = 1'b0;
        faulted    = 1'b0;
        mot_since  = 0;
        next_pulse = 0;
        ph_since   = 0;
        last_seen  = -1;
        ph         = PH_IDLE;
        err_snap   = '0;

        dir_tab.push_back(typed(dir_row(KIND_POLL, 0, 0, 1, 1, 0, 1), RES_QUIET));
        dir_tab.push_back(typed(dir_row(KIND_UNUSED, 0, 1, 0, 0, 0, 0), RES_QUIET));
        dir_tab.push_back(typed(dir_row(KIND_POLL, 1, 0, 0, 1, 0, 1), RES_FAULT));
        dir_tab.push_back(typed(dir_row(KIND_RETRY, 2, 0, 1, 0, 0, 1), RES_FAULT));
        dir_tab.push_back(typed(dir_row(KIND_RETRY, 2, 0, 1, 1, 0, 1), RES_RETRY));
        dir_tab.push_back(typed(dir_row(KIND_POLL, -TMAX - 1, 0, 1, 1, 0, 1), RES_FAULT));
        dir_tab.push_back(typed(dir_row(KIND_RETRY, 3, 0, 1, 1, 0, 1), RES_RETRY));
        dir_tab.push_back(dir_row(KIND_SET_WANTED, 10, 1, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_SET_WANTED, 20, 1, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 200, 0, 1, 0, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 300, 0, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 1300, 0, 1, 1, 32'hFFFF_FFFF, 1));
        // error count moves while the clip is ours
        dir_tab.push_back(dir_row(KIND_POLL, 1400, 0, 1, 0, 0, 1));
        dir_tab.push_back(dir_row(KIND_RETRY, 1399, 0, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_RETRY, 1500, 0, 0, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_RETRY, 1600, 0, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 6601, 0, 1, 0, 0, 1));
        // refused start: motor goes on and off in one event
        dir_tab.push_back(dir_row(KIND_RETRY, 6700, 0, 1, 1, 0, 0));
        dir_tab.push_back(dir_row(KIND_RETRY, 6800, 0, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_SET_WANTED, 6900, 0, 1, 0, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 12000, 0, 1, 0, 0, 1));
        dir_tab.push_back(dir_row(KIND_RETRY, 12001, 0, 1, 1, 0, 1));
        // foreign clip in the queue at start
        dir_tab.push_back(dir_row(KIND_SET_WANTED, 12002, 1, 1, 0, 0, 1));
        dir_tab.push_back(dir_row(KIND_RETRY, 12003, 0, 1, 1, 0, 1));
        dir_tab.push_back(dir_row(KIND_POLL, 12004, 0, 0, 1, 0, 1));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) send_row(dir_tab[i]);
        clock_ms = 12004;

        load_timing(5, 10, 40, 8);
        run_random(300);
        load_timing(1, 0, 1, 0);
        run_random(200);
        load_timing($urandom_range(1, 30), $urandom_range(30), $urandom_range(1, 60),
                    $urandom_range(30));
        run_random(300);
        load_timing(65535, 65535, 65535, 65535);
        step_max = 70000;
        run_random(80);
        load_timing($urandom_range(1, 30), $urandom_range(30), $urandom_range(1, 60),
                    $urandom_range(30));
        run_random(240);
        // close to the top of the time range: next pulse time saturates
        load_timing(10, 65535, 50, 5);
        clock_ms = TMAX - 70000;
        step_max = 400;
        run_random(180);

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------- result checking ----------------
    task automatic check_field(string nm, logic [1:0] exp_v, logic [1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, nm, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing pending", $time);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("motor_on", want.motor_on, o_motor_on);
                check_field("motor_edge", want.motor_edge, o_motor_edge);
                check_field("start_request", want.start_request, o_start_request);
                check_field("cancel_request", want.cancel_request, o_cancel_request);
                check_field("fault_flag", want.fault_flag, o_fault_flag);
                check_field("retry_accepted", want.retry_accepted, o_retry_accepted);
                check_field("clip_phase", want.clip_phase, o_clip_phase);
            end
        end
    end

endmodule

>>> files.f
+incdir+src
src/apcs_pkg.sv
src/apcs_in_reg.sv
src/apcs_core.sv
src/apcs_out_reg.sv
src/alarm_pulse_and_clip_sequencer.sv
tb/alarm_pulse_and_clip_sequencer_test.sv
